// File: design/sbc_pkg.sv
// shared types, constants and saturation helper for the basis coordinate solver
package sbc_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int FIFO_DEPTH_DEF = 4;
    localparam int WORD_W         = 32;
    localparam int NUM_ROWS       = 3;
    localparam int NUM_COLS       = 4;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef struct packed {
        t_word basis1_x;
        t_word basis1_y;
        t_word basis1_z;
        t_word basis2_x;
        t_word basis2_y;
        t_word basis2_z;
        t_word basis3_x;
        t_word basis3_y;
        t_word basis3_z;
        t_word point_x;
        t_word point_y;
        t_word point_z;
    } t_in;

    typedef struct packed {
        t_word coord_first;
        t_word coord_second;
        t_word coord_third;
        logic  singular;
    } t_out;

    // augmented matrix, row index first
    typedef t_word [NUM_ROWS-1:0][NUM_COLS-1:0] t_mat;

    typedef struct packed {
        t_mat a;
        logic sing;
    } t_sys;

    localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

    function automatic t_word sat_w(input logic signed [65:0] v);
        t_word res;
        if (v > SAT_HI) begin
            res = 32'sh7fffffff;
        end else if (v < SAT_LO) begin
            res = 32'sh80000000;
        end else begin
            res = v[WORD_W-1:0];
        end
        return res;
    endfunction

endpackage

// File: design/sbc_front.sv
// front end: takes input items, builds the augmented matrix, flags a zero first pivot
module sbc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  sbc_pkg::t_in  i_data,
    output logic          o_valid,
    output sbc_pkg::t_sys o_sys,
    input  logic          i_full
);
    import sbc_pkg::*;

    logic r_valid;
    logic n_valid;
    t_sys r_sys;
    t_sys n_sys;
    logic accept;
    logic push;

    assign o_stall = r_valid && i_full;
    assign accept  = i_valid && !o_stall;
    assign push    = r_valid && !i_full;
    assign o_valid = r_valid;
    assign o_sys   = r_sys;

    always_comb begin
        n_sys.a[0][0] = i_data.basis1_x;
        n_sys.a[1][0] = i_data.basis1_y;
        n_sys.a[2][0] = i_data.basis1_z;
        n_sys.a[0][1] = i_data.basis2_x;
        n_sys.a[1][1] = i_data.basis2_y;
        n_sys.a[2][1] = i_data.basis2_z;
        n_sys.a[0][2] = i_data.basis3_x;
        n_sys.a[1][2] = i_data.basis3_y;
        n_sys.a[2][2] = i_data.basis3_z;
        n_sys.a[0][3] = i_data.point_x;
        n_sys.a[1][3] = i_data.point_y;
        n_sys.a[2][3] = i_data.point_z;
        n_sys.sing    = (i_data.basis1_x == '0);
    end

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sys <= n_sys;
        end
    end

endmodule

// File: design/sbc_fifo.sv
// short item queue between front and back
module sbc_fifo #(
    parameter int DEPTH = sbc_pkg::FIFO_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  sbc_pkg::t_sys i_wdata,
    output logic          o_full,
    input  logic          i_rd,
    output sbc_pkg::t_sys o_rdata,
    output logic          o_nempty
);
    import sbc_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_sys           r_mem [DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;
    logic [PW-1:0]  n_wp;
    logic [PW-1:0]  n_rp;
    logic [CW-1:0]  n_cnt;
    logic           do_wr;
    logic           do_rd;

    assign o_full   = (r_cnt == FULL);
    assign o_nempty = (r_cnt != '0);
    assign o_rdata  = r_mem[r_rp];
    assign do_wr    = i_wr && !o_full;
    assign do_rd    = i_rd && o_nempty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_wr) begin
            n_wp = (r_wp == LAST) ? '0 : r_wp + 1'b1;
        end
        if (do_rd) begin
            n_rp = (r_rp == LAST) ? '0 : r_rp + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

// File: design/sbc_step.sv
// one elimination step: pivot check, three pipelined dividers, multiply, subtract
module sbc_step #(
    parameter int FRAC_BITS = sbc_pkg::FRAC_BITS_DEF,
    parameter int LEAD      = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  sbc_pkg::t_sys i_sys,
    output logic          o_valid,
    output sbc_pkg::t_sys o_sys
);
    import sbc_pkg::*;

    localparam int QW = WORD_W;
    localparam int DW = QW + FRAC_BITS;
    localparam int NL = 3;
    localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic [QW:0] QCAP = {2'b01, {(QW-1){1'b0}}};

    typedef struct packed {
        logic [QW-1:0] rem;
        logic [QW-1:0] dlo;
        logic [QW-1:0] q;
        logic          ovf;
        logic          neg;
    } t_lane;

    typedef t_lane [NL-1:0] t_lanes;

    logic          r_v   [0:QW];
    t_sys          r_s   [0:QW];
    t_lanes        r_l   [0:QW];
    logic [QW-1:0] r_ub  [0:QW];

    t_sys          n_s0;
    t_lanes        n_l0;
    logic [QW-1:0] n_ub0;

    // lane j divides a[j][LEAD] for rows above the pivot, else pivot row column j+1
    always_comb begin
        t_word         p;
        t_word         num;
        logic [QW-1:0] ua;
        logic [DW-1:0] d;
        p     = i_sys.a[LEAD][LEAD];
        n_ub0 = p[QW-1] ? (~p + 1'b1) : p;
        n_s0  = i_sys;
        n_s0.sing = i_sys.sing | (p == '0);
        for (int j = 0; j < NL; j++) begin
            num = (j < LEAD) ? i_sys.a[j][LEAD] : i_sys.a[LEAD][j+1];
            ua  = num[QW-1] ? (~num + 1'b1) : num;
            d   = (DW'(ua) << FRAC_BITS) + DW'(n_ub0 >> 1);
            n_l0[j].neg = num[QW-1] ^ p[QW-1];
            n_l0[j].rem = QW'(d >> QW);
            n_l0[j].dlo = d[QW-1:0];
            n_l0[j].q   = '0;
            n_l0[j].ovf = (d >> QW) >= DW'(n_ub0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s[0]  <= n_s0;
            r_l[0]  <= n_l0;
            r_ub[0] <= n_ub0;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_div
        t_lanes n_l;

        always_comb begin
            logic [QW:0] ext;
            n_l = r_l[k-1];
            for (int j = 0; j < NL; j++) begin
                ext = {r_l[k-1][j].rem, r_l[k-1][j].dlo[QW-1]};
                n_l[j].dlo = r_l[k-1][j].dlo << 1;
                if (ext >= {1'b0, r_ub[k-1]}) begin
                    n_l[j].rem = QW'(ext - {1'b0, r_ub[k-1]});
                    n_l[j].q   = {r_l[k-1][j].q[QW-2:0], 1'b1};
                end else begin
                    n_l[j].rem = ext[QW-1:0];
                    n_l[j].q   = {r_l[k-1][j].q[QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s[k]  <= r_s[k-1];
                r_l[k]  <= n_l;
                r_ub[k] <= r_ub[k-1];
            end
        end
    end

    // quotient rounding is already in the dividend; here cap and apply sign
    logic  r_fv;
    t_sys  r_fs;
    t_word r_fq [NL];
    t_word n_fq [NL];

    always_comb begin
        logic [QW:0] qm;
        for (int j = 0; j < NL; j++) begin
            qm = {1'b0, r_l[QW][j].q};
            if (r_l[QW][j].ovf || qm > QCAP) begin
                qm = QCAP;
            end
            if (r_l[QW][j].neg) begin
                n_fq[j] = QW'(~qm + 1'b1);
            end else if (qm == QCAP) begin
                n_fq[j] = 32'sh7fffffff;
            end else begin
                n_fq[j] = qm[QW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (i_en) begin
            r_fv <= r_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fs <= r_s[QW];
            r_fq <= n_fq;
        end
    end

    // rows below the pivot use the unchanged entry as factor, since the pivot is one
    logic                     r_mv;
    t_sys                     r_ms;
    t_word                    r_mq   [NL];
    logic signed [2*QW-1:0]   r_prod [2][NUM_COLS];
    logic signed [2*QW-1:0]   n_prod [2][NUM_COLS];

    always_comb begin
        int    ro;
        t_word mfac;
        t_word src;
        for (int o = 0; o < 2; o++) begin
            ro = (o < LEAD) ? o : o + 1;
            for (int c = 0; c < NUM_COLS; c++) begin
                n_prod[o][c] = '0;
                if (c > LEAD) begin
                    mfac = (ro < LEAD) ? r_fq[ro] : r_fs.a[ro][LEAD];
                    src  = (ro < LEAD) ? r_fs.a[LEAD][c] : r_fq[c-1];
                    n_prod[o][c] = $signed(src) * $signed(mfac);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (i_en) begin
            r_mv <= r_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ms   <= r_fs;
            r_mq   <= r_fq;
            r_prod <= n_prod;
        end
    end

    logic r_ov;
    t_sys r_os;
    t_sys n_os;

    always_comb begin
        int                ro;
        logic signed [65:0] rnd;
        logic signed [65:0] diff;
        t_word             pm;
        n_os = r_ms;
        for (int c = 0; c < NUM_COLS; c++) begin
            if (c > LEAD) begin
                n_os.a[LEAD][c] = r_mq[c-1];
            end
        end
        for (int o = 0; o < 2; o++) begin
            ro = (o < LEAD) ? o : o + 1;
            for (int c = 0; c < NUM_COLS; c++) begin
                if (c > LEAD) begin
                    rnd  = 66'(r_prod[o][c]) + HALF;
                    pm   = sat_w(rnd >>> FRAC_BITS);
                    diff = 66'($signed(r_ms.a[ro][c])) - 66'(pm);
                    n_os.a[ro][c] = sat_w(diff);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_os <= n_os;
        end
    end

    assign o_valid = r_ov;
    assign o_sys   = r_os;

endmodule

// File: design/sbc_back.sv
// back end: three elimination steps in a stall-together pipeline and the result register
module sbc_back #(
    parameter int FRAC_BITS = sbc_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  sbc_pkg::t_sys i_q_sys,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output sbc_pkg::t_out o_data
);
    import sbc_pkg::*;

    logic en;
    logic v   [0:NUM_ROWS];
    t_sys s   [0:NUM_ROWS];
    logic r_out_v;
    t_out r_out;
    t_out n_out;

    // whole pipeline moves whenever the result register is free or being taken
    assign en    = !r_out_v || !i_stall;
    assign o_pop = en && i_q_valid;
    assign v[0]  = i_q_valid;
    assign s[0]  = i_q_sys;

    for (genvar l = 0; l < NUM_ROWS; l++) begin : g_step
        sbc_step #(
            .FRAC_BITS (FRAC_BITS),
            .LEAD      (l)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v[l]),
            .i_sys   (s[l]),
            .o_valid (v[l+1]),
            .o_sys   (s[l+1])
        );
    end

    always_comb begin
        n_out.singular = s[NUM_ROWS].sing;
        if (s[NUM_ROWS].sing) begin
            n_out.coord_first  = '0;
            n_out.coord_second = '0;
            n_out.coord_third  = '0;
        end else begin
            n_out.coord_first  = s[NUM_ROWS].a[0][3];
            n_out.coord_second = s[NUM_ROWS].a[1][3];
            n_out.coord_third  = s[NUM_ROWS].a[2][3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= v[NUM_ROWS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

// File: design/solve_basis_coordinates_core.sv
// pipeline order: input register, queue, 3 steps, result register
// each step: pivot check, 32 one-bit divider stages, rounding, multiply, subtract
// throughput: one item per cycle while the result is not stalled; the divider and multiplier stages are fully pipelined
// a stalled result holds the whole back pipeline; the queue keeps taking items until full
// reset clears all valid bits and queue pointers; payload registers are not reset
// top level: front end, item queue, back end
module solve_basis_coordinates_core #(
    parameter int FRAC_BITS  = sbc_pkg::FRAC_BITS_DEF,
    parameter int FIFO_DEPTH = sbc_pkg::FIFO_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  sbc_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output sbc_pkg::t_out o_data
);
    import sbc_pkg::*;

    logic f_valid;
    t_sys f_sys;
    logic q_full;
    logic q_nempty;
    t_sys q_sys;
    logic pop;

    sbc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (f_valid),
        .o_sys   (f_sys),
        .i_full  (q_full)
    );

    sbc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (f_valid),
        .i_wdata  (f_sys),
        .o_full   (q_full),
        .i_rd     (pop),
        .o_rdata  (q_sys),
        .o_nempty (q_nempty)
    );

    sbc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_nempty),
        .i_q_sys   (q_sys),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_data    (o_data)
    );

endmodule
